// File: src/vga_pkg.sv
package vga_pkg;

   // Field widths of the items.
   localparam int FUNC_W   = 2;
   localparam int INDEX_W  = 19;
   localparam int NODE_W   = 18;
   localparam int STATUS_W = 2;
   localparam int GRID_W   = 7;
   localparam int MODE_W   = 2;
   localparam int CSR_W    = 2;

   // A map entry is a valid bit over a node id.
   localparam int ENTRY_W = NODE_W + 1;

   // Counter of assigned node ids; its top bit means the id space is used up.
   localparam int COUNT_W = NODE_W + 1;

   // The divider takes a voxel index apart one quotient bit per step.
   localparam int DIV_STEPS = INDEX_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   // Function codes of an input item.
   localparam logic [FUNC_W-1:0] FN_LOAD  = 2'd0;
   localparam logic [FUNC_W-1:0] FN_QUERY = 2'd1;
   localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd2;
   localparam logic [FUNC_W-1:0] FN_NONE  = 2'd3;

   // Status codes of a result item.
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // Connectivity modes.
   localparam logic [MODE_W-1:0] CONN_6  = 2'd0;
   localparam logic [MODE_W-1:0] CONN_18 = 2'd1;

   // Configuration register indexes.
   localparam logic [CSR_W-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_W-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_W-1:0] CSR_SIZE_Z = 2'd2;
   localparam logic [CSR_W-1:0] CSR_MODE   = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [INDEX_W-1:0] voxel_index;
      logic [NODE_W-1:0]  query_node;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [NODE_W-1:0]   node_a;
      logic [NODE_W-1:0]   node_b;
      logic                edge_valid;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [GRID_W-1:0] size_x;
      logic [GRID_W-1:0] size_y;
      logic [GRID_W-1:0] size_z;
      logic [MODE_W-1:0] mode;
   } cfg_type;

   typedef struct packed {
      logic               start;
      logic [INDEX_W-1:0] dividend;
      logic [GRID_W-1:0]  divisor;
   } div_cmd_type;

   typedef struct packed {
      logic               done;
      logic [INDEX_W-1:0] quotient;
      logic [GRID_W-1:0]  remainder;
   } div_rsp_type;

   typedef struct packed {
      logic enable;
      logic write;
   } map_ctl_type;

endpackage

// File: src/vga_div.sv
module vga_div (
   input  logic                 clock,
   input  logic                 reset,
   input  vga_pkg::div_cmd_type div_cmd,
   output vga_pkg::div_rsp_type div_rsp
);
   import vga_pkg::*;

   logic                 active_ff, active_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [INDEX_W-1:0]   quo_ff, quo_in;
   logic [GRID_W-1:0]    rem_ff, rem_in;
   logic [GRID_W-1:0]    dvs_ff, dvs_in;
   logic [GRID_W:0]      rem_sh;
   logic [GRID_W:0]      rem_sub;
   logic                 fits;

   // One restoring step: shift in the next dividend bit and try the subtract.
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[INDEX_W-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      fits    = rem_sh >= {1'b0, dvs_ff};
   end

   // Step sequencing.
   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      if (div_cmd.start) begin
         active_in = 1'b1;
         cnt_in    = DIV_CNT_W'(DIV_STEPS);
         quo_in    = div_cmd.dividend;
         rem_in    = '0;
         dvs_in    = div_cmd.divisor;
      end else if (active_ff) begin
         cnt_in = cnt_ff - 1'b1;
         quo_in = {quo_ff[INDEX_W-2:0], fits};
         rem_in = fits ? rem_sub[GRID_W-1:0] : rem_sh[GRID_W-1:0];
         if (cnt_ff == DIV_CNT_W'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// File: src/vga_map.sv
module vga_map #(
   parameter int DEPTH = 262144,
   parameter int AW    = 18
) (
   input  logic                        clock,
   input  vga_pkg::map_ctl_type        map_ctl,
   input  logic [AW-1:0]               map_addr,
   input  logic [vga_pkg::ENTRY_W-1:0] map_wdata,
   output logic [vga_pkg::ENTRY_W-1:0] map_rdata
);
   import vga_pkg::*;

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rdata_ff;

   // Single port: one write or one registered read per cycle.
   always_ff @(posedge clock) begin
      if (map_ctl.enable) begin
         if (map_ctl.write) begin
            mem[map_addr] <= map_wdata;
         end else begin
            rdata_ff <= mem[map_addr];
         end
      end
   end

   assign map_rdata = rdata_ff;

endmodule

// File: src/vga_seq.sv
module vga_seq #(
   parameter int MAX_VOXELS     = 262144,
   parameter int MAX_NEIGHBOURS = 26,
   parameter int AW             = 18
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  vga_pkg::req_type            req_data,
   input  vga_pkg::cfg_type            cfg,
   output logic                        rsp_valid,
   output vga_pkg::rsp_type            rsp_data,
   output vga_pkg::div_cmd_type        div_cmd,
   input  vga_pkg::div_rsp_type        div_rsp,
   output vga_pkg::map_ctl_type        map_ctl,
   output logic [AW-1:0]               map_addr,
   output logic [vga_pkg::ENTRY_W-1:0] map_wdata,
   input  logic [vga_pkg::ENTRY_W-1:0] map_rdata
);
   import vga_pkg::*;

   localparam int          EW       = $clog2(MAX_NEIGHBOURS + 1);
   localparam logic [31:0] MAXV     = 32'(MAX_VOXELS);
   localparam logic [AW-1:0] CLR_LAST = AW'(MAX_VOXELS - 1);
   localparam int          NXY_W    = 2 * GRID_W;
   localparam int          TOT_W    = 3 * GRID_W;
   localparam int          NL_W     = TOT_W + 1;

   // Sequencer states.
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CLEAR  = 4'd1;
   localparam logic [3:0] S_PREP   = 4'd2;
   localparam logic [3:0] S_TOTAL  = 4'd3;
   localparam logic [3:0] S_CHECK  = 4'd4;
   localparam logic [3:0] S_DIVX   = 4'd5;
   localparam logic [3:0] S_DIVY   = 4'd6;
   localparam logic [3:0] S_NEIGH  = 4'd7;
   localparam logic [3:0] S_DRAIN  = 4'd8;
   localparam logic [3:0] S_FINISH = 4'd9;

   // Offset digit codes along one axis.
   localparam logic [1:0] OFF_NEG  = 2'd0;
   localparam logic [1:0] OFF_ZERO = 2'd1;
   localparam logic [1:0] OFF_POS  = 2'd2;

   logic [3:0]         state_ff, state_in;
   req_type            req_ff, req_in;
   logic [INDEX_W-1:0] lin_ff, lin_in;
   logic [NXY_W-1:0]   nxy_ff, nxy_in;
   logic [TOT_W-1:0]   total_ff, total_in;
   logic [GRID_W-1:0]  x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [1:0]         dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic               rd_pend_ff, rd_pend_in;
   logic               pend_ff, pend_in;
   logic [NODE_W-1:0]  pend_id_ff, pend_id_in;
   logic [EW-1:0]      ecnt_ff, ecnt_in;
   logic [COUNT_W-1:0] counter_ff, counter_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic               clr_emit_ff, clr_emit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               in_range;
   logic [1:0]         man;
   logic               man_ok, x_ok, y_ok, z_ok, nl_ok, issue, hit;
   logic [NL_W-1:0]    off_x, off_y, off_z, nl;

   assign busy = state_ff != S_IDLE;

   // Range test of the latched voxel index.
   assign in_range = (req_ff.voxel_index != '0)
                     && ({2'b0, lin_ff} < total_ff)
                     && (32'(lin_ff) < MAXV);

   // Neighbour at the current offset: class, bounds and linear index.
   always_comb begin
      man = 2'(dx_ff != OFF_ZERO) + 2'(dy_ff != OFF_ZERO) + 2'(dz_ff != OFF_ZERO);
      unique case (cfg.mode)
         CONN_6:  man_ok = man == 2'd1;
         CONN_18: man_ok = (man == 2'd1) || (man == 2'd2);
         default: man_ok = man != 2'd0;
      endcase
      x_ok = (dx_ff == OFF_NEG) ? (x_ff != '0) :
             (dx_ff == OFF_POS) ? (x_ff != cfg.size_x - 1'b1) : 1'b1;
      y_ok = (dy_ff == OFF_NEG) ? (y_ff != '0) :
             (dy_ff == OFF_POS) ? (y_ff != cfg.size_y - 1'b1) : 1'b1;
      z_ok = (dz_ff == OFF_NEG) ? (z_ff != '0) :
             (dz_ff == OFF_POS) ? (z_ff != cfg.size_z - 1'b1) : 1'b1;
      off_x = (dx_ff == OFF_NEG) ? '1 :
              (dx_ff == OFF_POS) ? NL_W'(1) : '0;
      off_y = (dy_ff == OFF_NEG) ? -NL_W'(cfg.size_x) :
              (dy_ff == OFF_POS) ? NL_W'(cfg.size_x) : '0;
      off_z = (dz_ff == OFF_NEG) ? -NL_W'(nxy_ff) :
              (dz_ff == OFF_POS) ? NL_W'(nxy_ff) : '0;
      nl    = NL_W'(lin_ff) + off_x + off_y + off_z;
      nl_ok = 32'(nl) < MAXV;
      issue = (state_ff == S_NEIGH) && man_ok && x_ok && y_ok && z_ok && nl_ok;
   end

   // A read that came back valid with a higher node id makes an edge, while the edge counter is below its limit.
   assign hit = rd_pend_ff && map_rdata[ENTRY_W-1]
                && (map_rdata[NODE_W-1:0] > req_ff.query_node)
                && (ecnt_ff < EW'(MAX_NEIGHBOURS));

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      lin_in       = lin_ff;
      nxy_in       = nxy_ff;
      total_in     = total_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dz_in        = dz_ff;
      rd_pend_in   = 1'b0;
      pend_in      = pend_ff;
      pend_id_in   = pend_id_ff;
      ecnt_in      = ecnt_ff;
      counter_in   = counter_ff;
      clr_in       = clr_ff;
      clr_emit_in  = clr_emit_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      div_cmd      = '0;
      map_ctl      = '0;
      map_addr     = '0;
      map_wdata    = '0;

      // Edges found during the neighbour walk go out one behind, so that
      // the final one can carry the last flag.
      if (hit) begin
         if (pend_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{status: ST_OK, node_a: req_ff.query_node,
                             node_b: pend_id_ff, edge_valid: 1'b1, last: 1'b0};
         end
         pend_in    = 1'b1;
         pend_id_in = map_rdata[NODE_W-1:0];
         ecnt_in    = ecnt_ff + 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               lin_in   = req_data.voxel_index - 1'b1;
               state_in = S_PREP;
            end
         end
         S_CLEAR: begin
            map_ctl   = '{enable: 1'b1, write: 1'b1};
            map_addr  = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
               if (clr_emit_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: ST_OK, node_a: '0, node_b: '0,
                                   edge_valid: 1'b0, last: 1'b1};
               end
            end
         end
         S_PREP: begin
            nxy_in = NXY_W'(cfg.size_x) * NXY_W'(cfg.size_y);
            if (req_ff.func == FN_CLEAR) begin
               counter_in  = '0;
               clr_in      = '0;
               clr_emit_in = 1'b1;
               state_in    = S_CLEAR;
            end else if (req_ff.func == FN_NONE) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_TOTAL;
            end
         end
         S_TOTAL: begin
            total_in = TOT_W'(nxy_ff) * TOT_W'(cfg.size_z);
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!in_range) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_RANGE, node_a: '0, node_b: '0,
                                edge_valid: 1'b0, last: 1'b1};
               state_in     = S_IDLE;
            end else if (req_ff.func == FN_LOAD) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (counter_ff[COUNT_W-1]) begin
                  rsp_in = '{status: ST_FULL, node_a: '0, node_b: '0,
                             edge_valid: 1'b0, last: 1'b1};
               end else begin
                  map_ctl    = '{enable: 1'b1, write: 1'b1};
                  map_addr   = AW'(lin_ff);
                  map_wdata  = {1'b1, counter_ff[NODE_W-1:0]};
                  rsp_in     = '{status: ST_OK, node_a: counter_ff[NODE_W-1:0],
                                 node_b: '0, edge_valid: 1'b0, last: 1'b1};
                  counter_in = counter_ff + 1'b1;
               end
            end else begin
               div_cmd  = '{start: 1'b1, dividend: lin_ff, divisor: cfg.size_x};
               state_in = S_DIVX;
            end
         end
         S_DIVX: begin
            if (div_rsp.done) begin
               x_in     = div_rsp.remainder;
               div_cmd  = '{start: 1'b1, dividend: div_rsp.quotient,
                            divisor: cfg.size_y};
               state_in = S_DIVY;
            end
         end
         S_DIVY: begin
            if (div_rsp.done) begin
               y_in     = div_rsp.remainder;
               z_in     = div_rsp.quotient[GRID_W-1:0];
               dx_in    = OFF_NEG;
               dy_in    = OFF_NEG;
               dz_in    = OFF_NEG;
               pend_in  = 1'b0;
               ecnt_in  = '0;
               state_in = S_NEIGH;
            end
         end
         S_NEIGH: begin
            // One offset per cycle, dz fastest, each digit running -1, 0, +1.
            if (issue) begin
               map_ctl    = '{enable: 1'b1, write: 1'b0};
               map_addr   = AW'(nl);
               rd_pend_in = 1'b1;
            end
            if (dz_ff != OFF_POS) begin
               dz_in = dz_ff + 1'b1;
            end else begin
               dz_in = OFF_NEG;
               if (dy_ff != OFF_POS) begin
                  dy_in = dy_ff + 1'b1;
               end else begin
                  dy_in = OFF_NEG;
                  if (dx_ff != OFF_POS) begin
                     dx_in = dx_ff + 1'b1;
                  end else begin
                     state_in = S_DRAIN;
                  end
               end
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            rsp_valid_in = 1'b1;
            if (pend_ff) begin
               rsp_in = '{status: ST_OK, node_a: req_ff.query_node,
                          node_b: pend_id_ff, edge_valid: 1'b1, last: 1'b1};
            end else begin
               rsp_in = '{status: ST_OK, node_a: '0, node_b: '0,
                          edge_valid: 1'b0, last: 1'b1};
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state; reset starts the sweep that marks every map entry empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         clr_emit_ff  <= 1'b0;
         counter_ff   <= '0;
         rd_pend_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         ecnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_emit_ff  <= clr_emit_in;
         counter_ff   <= counter_in;
         rd_pend_ff   <= rd_pend_in;
         pend_ff      <= pend_in;
         ecnt_ff      <= ecnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      lin_ff     <= lin_in;
      nxy_ff     <= nxy_in;
      total_ff   <= total_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      dz_ff      <= dz_in;
      pend_id_ff <= pend_id_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: src/voxel_grid_adjacency.sv
// Channel    Ports                               Moves
// input      start, busy, req_data               one item when start is high and busy low
// result     rsp_valid, rsp_data                 one item in each cycle rsp_valid is high
// config     csr_we, csr_index, csr_wdata        one register write when csr_we is high
//
// A load or an out-of-range item gives its result from S_CHECK, after S_PREP and S_TOTAL.
// A query makes two 19-step passes of the shared divider, then walks the 27 neighbour
// offset slots, with a map read for each neighbour in bounds and class on the single map port.
// A clear item, and reset itself, sweep the map one entry a cycle over all
// MAX_VOXELS entries, during which busy stays high.
// Results cannot be held off; busy is low again in the cycle of the last one.
module voxel_grid_adjacency #(
   parameter int MAX_VOXELS     = 262144,
   parameter int MAX_NEIGHBOURS = 26
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  vga_pkg::req_type          req_data,
   output logic                      rsp_valid,
   output vga_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [vga_pkg::CSR_W-1:0] csr_index,
   input  logic [vga_pkg::GRID_W-1:0] csr_wdata
);
   import vga_pkg::*;

   localparam int AW = $clog2(MAX_VOXELS);

   logic [GRID_W-1:0]  size_x_ff, size_x_in;
   logic [GRID_W-1:0]  size_y_ff, size_y_in;
   logic [GRID_W-1:0]  size_z_ff, size_z_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   cfg_type            cfg;
   div_cmd_type        div_cmd;
   div_rsp_type        div_rsp;
   map_ctl_type        map_ctl;
   logic [AW-1:0]      map_addr;
   logic [ENTRY_W-1:0] map_wdata;
   logic [ENTRY_W-1:0] map_rdata;

   // Configuration register writes.
   always_comb begin
      size_x_in = size_x_ff;
      size_y_in = size_y_ff;
      size_z_in = size_z_ff;
      mode_in   = mode_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SIZE_X: size_x_in = csr_wdata;
            CSR_SIZE_Y: size_y_in = csr_wdata;
            CSR_SIZE_Z: size_z_in = csr_wdata;
            CSR_MODE:   mode_in   = csr_wdata[MODE_W-1:0];
            default:    mode_in   = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= GRID_W'(64);
         size_y_ff <= GRID_W'(64);
         size_z_ff <= GRID_W'(64);
         mode_ff   <= CONN_6;
      end else begin
         size_x_ff <= size_x_in;
         size_y_ff <= size_y_in;
         size_z_ff <= size_z_in;
         mode_ff   <= mode_in;
      end
   end

   assign cfg = '{size_x: size_x_ff, size_y: size_y_ff, size_z: size_z_ff, mode: mode_ff};

   vga_seq #(
      .MAX_VOXELS     (MAX_VOXELS),
      .MAX_NEIGHBOURS (MAX_NEIGHBOURS),
      .AW             (AW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .div_cmd   (div_cmd),
      .div_rsp   (div_rsp),
      .map_ctl   (map_ctl),
      .map_addr  (map_addr),
      .map_wdata (map_wdata),
      .map_rdata (map_rdata)
   );

   vga_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_cmd (div_cmd),
      .div_rsp (div_rsp)
   );

   vga_map #(
      .DEPTH (MAX_VOXELS),
      .AW    (AW)
   ) u_map (
      .clock     (clock),
      .map_ctl   (map_ctl),
      .map_addr  (map_addr),
      .map_wdata (map_wdata),
      .map_rdata (map_rdata)
   );

   // The final result of an item leaves the block ready for the next one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> !busy)
      else $error("busy still high with the last result of an item");

   // Results before the last one come while the item is still at work.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> busy)
      else $error("non-final result with the block idle");

   // Edges always carry an ok status and a higher neighbour id.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.edge_valid |->
         rsp_data.status == ST_OK && rsp_data.node_b > rsp_data.node_a)
      else $error("malformed edge result");

   // A result before the last one follows a cycle in which the block was at work.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> $past(busy))
      else $error("result without an item at work");

endmodule
